// ===== rtl/fuc_pkg.sv =====
// shared constants and controller/datapath command type for the minute counter
`default_nettype none

package fuc_pkg;

	localparam int STORE_BYTES = 128;
	localparam int IDX_W = $clog2(STORE_BYTES);
	localparam int POS_W = 7;

	localparam logic [31:0] PERIOD_RESET = 32'd60000;
	localparam logic [7:0] BYTE_ERASED = 8'hFF;
	localparam logic [7:0] BYTE_FIRST = 8'hFE;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STORE_BYTES - 1);

	typedef struct packed {
		logic load;   // capture the request's time sample
		logic eval;   // compare against the due time
		logic commit; // update counter state and load the result register
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/fuc_if.sv =====
// valid/ready channel interfaces for time samples and results
`default_nettype none

interface fuc_in_if;
	logic valid;
	logic ready;
	logic [31:0] now_ms;

	modport source (output valid, output now_ms, input ready);
	modport sink (input valid, input now_ms, output ready);
endinterface

interface fuc_out_if;
	logic valid;
	logic ready;
	logic minute_counted;
	logic [31:0] minute_total;
	logic [fuc_pkg::POS_W-1:0] minute_byte_position;
	logic [fuc_pkg::POS_W-1:0] page_byte_position;
	logic store_full_event;

	modport source (output valid, output minute_counted, output minute_total,
		output minute_byte_position, output page_byte_position,
		output store_full_event, input ready);
	modport sink (input valid, input minute_counted, input minute_total,
		input minute_byte_position, input page_byte_position,
		input store_full_event, output ready);
endinterface

`default_nettype wire

// ===== rtl/fuc_datapath.sv =====
// tick compare, minute total and the two unary stores with the result register
`default_nettype none

module fuc_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire fuc_pkg::cmd_t              cmd,
	input  wire logic                       cfg_wr_en,
	input  wire logic [31:0]                cfg_wr_data,
	input  wire logic [31:0]                now_ms,
	output logic                            minute_counted,
	output logic [31:0]                     minute_total,
	output logic [fuc_pkg::POS_W-1:0]       minute_byte_position,
	output logic [fuc_pkg::POS_W-1:0]       page_byte_position,
	output logic                            store_full_event
);

	logic [31:0] period_q;
	logic [31:0] now_q;
	logic        due_q;
	logic [31:0] last_tick_q;
	logic [31:0] total_q;
	// only the active byte of each store is kept: bytes behind it are zero,
	// bytes ahead of it are erased
	logic [fuc_pkg::IDX_W-1:0] midx_q;
	logic [fuc_pkg::IDX_W-1:0] pidx_q;
	logic [7:0] mbyte_q;
	logic [7:0] pbyte_q;

	logic [31:0] total_d;
	logic [fuc_pkg::IDX_W-1:0] midx_d;
	logic [fuc_pkg::IDX_W-1:0] pidx_d;
	logic [7:0] mbyte_d;
	logic [7:0] pbyte_d;
	logic full_d;

	always_comb begin
		total_d = total_q;
		midx_d = midx_q;
		pidx_d = pidx_q;
		mbyte_d = mbyte_q;
		pbyte_d = pbyte_q;
		full_d = 1'b0;
		if (due_q) begin
			total_d = total_q + 32'd1;
			if (mbyte_q != 8'h00) begin
				mbyte_d = {mbyte_q[6:0], 1'b0};
			end else if (midx_q != fuc_pkg::IDX_LAST) begin
				midx_d = midx_q + fuc_pkg::IDX_W'(1);
				mbyte_d = fuc_pkg::BYTE_FIRST;
			end else begin
				// minute store exhausted: count a page, then erase minutes
				midx_d = '0;
				mbyte_d = fuc_pkg::BYTE_ERASED;
				if (pbyte_q != 8'h00) begin
					pbyte_d = {pbyte_q[6:0], 1'b0};
				end else if (pidx_q != fuc_pkg::IDX_LAST) begin
					pidx_d = pidx_q + fuc_pkg::IDX_W'(1);
					pbyte_d = fuc_pkg::BYTE_FIRST;
				end else begin
					pidx_d = '0;
					pbyte_d = fuc_pkg::BYTE_ERASED;
					full_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= fuc_pkg::PERIOD_RESET;
			last_tick_q <= '0;
			total_q <= '0;
			midx_q <= '0;
			pidx_q <= '0;
			mbyte_q <= fuc_pkg::BYTE_ERASED;
			pbyte_q <= fuc_pkg::BYTE_ERASED;
		end else begin
			if (cfg_wr_en) begin
				period_q <= cfg_wr_data;
			end
			if (cmd.commit) begin
				if (due_q) begin
					last_tick_q <= now_q;
				end
				total_q <= total_d;
				midx_q <= midx_d;
				pidx_q <= pidx_d;
				mbyte_q <= mbyte_d;
				pbyte_q <= pbyte_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= now_ms;
		end
		if (cmd.eval) begin
			// due time wraps modulo 2^32 before the compare
			due_q <= (last_tick_q + period_q) <= now_q;
		end
		if (cmd.commit) begin
			minute_counted <= due_q;
			minute_total <= total_d;
			minute_byte_position <= fuc_pkg::POS_W'(midx_d);
			page_byte_position <= fuc_pkg::POS_W'(pidx_d);
			store_full_event <= full_d;
		end
	end

	a_midx_range: assert property (@(posedge clk) disable iff (!arst_n)
		midx_q <= fuc_pkg::IDX_LAST)
		else $error("minute index beyond store");

	a_erase_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && full_d |=> midx_q == '0 && pidx_q == '0)
		else $error("stores not erased on full event");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && due_q |=> total_q == $past(total_q) + 32'd1)
		else $error("minute total did not advance");

endmodule

`default_nettype wire

// ===== rtl/fuc_ctrl.sv =====
// request sequencing and result valid for the minute counter
`default_nettype none

module fuc_ctrl (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output fuc_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load = in_valid && in_ready;
		cmd.eval = (state_q == ST_EVAL);
		cmd.commit = (state_q == ST_COMMIT) && slot_free;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				// hold until the result register can take the new result
				if (slot_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_EVAL)
		else $error("accepted request did not start evaluation");

	a_eval_to_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |=> state_q == ST_COMMIT)
		else $error("evaluation did not reach commit");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q && state_q == ST_IDLE)
		else $error("commit did not present a result");

endmodule

`default_nettype wire

// ===== rtl/flash_unary_minute_counter.sv =====
// top level of the unary minute counter: controller plus datapath
// flow: a request passes EVAL, then COMMIT, which makes its result valid
// intake: a new request is taken only after the previous one has committed; it
//   is accepted while the previous result still waits in the output register
// the commit step stalls only when the output register is still occupied
// reset: async, active low; period 60000, time and total zero, both stores erased
`default_nettype none

module flash_unary_minute_counter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	fuc_in_if.sink           sample,
	fuc_out_if.source        result
);

	fuc_pkg::cmd_t cmd;

	fuc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	fuc_datapath u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.cfg_wr_en            (cfg_wr_en),
		.cfg_wr_data          (cfg_wr_data),
		.now_ms               (sample.now_ms),
		.minute_counted       (result.minute_counted),
		.minute_total         (result.minute_total),
		.minute_byte_position (result.minute_byte_position),
		.page_byte_position   (result.page_byte_position),
		.store_full_event     (result.store_full_event)
	);

endmodule

`default_nettype wire

// ===== tb/flash_unary_minute_counter_tb.sv =====
// self-checking testbench for the unary minute counter: directed table, then random samples
`timescale 1ns / 1ps

module flash_unary_minute_counter_tb;

	localparam int LVL_MINUTE = 0;
	localparam int LVL_PAGE = 1;
	localparam int MAX_IDLE = 14;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 280;

	typedef struct packed {
		logic counted;
		logic [31:0] total;
		logic [fuc_pkg::POS_W-1:0] minute_pos;
		logic [fuc_pkg::POS_W-1:0] page_pos;
		logic full;
	} minute_report_t;

	typedef enum logic {STEP_SAMPLE, STEP_PERIOD} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		logic [31:0] value;
		logic typed;
		minute_report_t want;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [31:0] cfg_wr_data;

	fuc_in_if sample_ch();
	fuc_out_if result_ch();

	flash_unary_minute_counter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.sample(sample_ch),
		.result(result_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted counter state
	logic [31:0] tick_period;
	logic [31:0] last_tick;
	logic [31:0] minute_sum;
	logic [7:0] store_cells [2][fuc_pkg::STORE_BYTES];
	logic [fuc_pkg::IDX_W-1:0] store_pos [2];

	minute_report_t awaited_reports [$];
	table_row_t directed_steps [$];
	bit steady_flow = 1'b0;
	int mismatches = 0;
	int samples_sent = 0;
	int minutes_counted = 0;
	int minute_rollovers = 0;
	int full_events = 0;
	int periods_set = 0;

	function automatic void erase_level(input int lvl);
		for (int i = 0; i < fuc_pkg::STORE_BYTES; i++)
			store_cells[lvl][i] = fuc_pkg::BYTE_ERASED;
		store_pos[lvl] = '0;
	endfunction

	// one unary step in a store; returns 1 when the store had nothing left
	function automatic bit mark_unary(input int lvl);
		if (store_cells[lvl][store_pos[lvl]] != 8'h00) begin
			store_cells[lvl][store_pos[lvl]] = store_cells[lvl][store_pos[lvl]] << 1;
			return 1'b0;
		end
		if (store_pos[lvl] != fuc_pkg::IDX_LAST) begin
			store_pos[lvl] = store_pos[lvl] + fuc_pkg::IDX_W'(1);
			store_cells[lvl][store_pos[lvl]] = fuc_pkg::BYTE_FIRST;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic minute_report_t tally_time_sample(input logic [31:0] now);
		minute_report_t r;
		logic [31:0] due;
		r = '0;
		due = last_tick + tick_period;
		if (due <= now) begin
			r.counted = 1'b1;
			minutes_counted++;
			last_tick = now;
			minute_sum = minute_sum + 32'd1;
			if (mark_unary(LVL_MINUTE)) begin
				minute_rollovers++;
				if (mark_unary(LVL_PAGE)) begin
					erase_level(LVL_PAGE);
					r.full = 1'b1;
					full_events++;
				end
				erase_level(LVL_MINUTE);
			end
		end
		r.total = minute_sum;
		r.minute_pos = fuc_pkg::POS_W'(store_pos[LVL_MINUTE]);
		r.page_pos = fuc_pkg::POS_W'(store_pos[LVL_PAGE]);
		return r;
	endfunction

	// mostly samples at or just past the due time, some just short, some anywhere
	function automatic logic [31:0] pick_now();
		int roll;
		logic [31:0] due;
		roll = $urandom_range(0, 99);
		due = last_tick + tick_period;
		if (roll < 75)
			return due + 32'($urandom_range(0, 3));
		if (roll < 85)
			return due - 32'($urandom_range(1, 4));
		return $urandom;
	endfunction

	function automatic int draw_idle();
		return steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	task automatic compare_report(input minute_report_t want, input minute_report_t got);
		if (want.counted !== got.counted) begin
			$display("%0t ns: minute_counted expected %0d actual %0d",
				$time, want.counted, got.counted);
			mismatches++;
		end
		if (want.total !== got.total) begin
			$display("%0t ns: minute_total expected %0d actual %0d",
				$time, want.total, got.total);
			mismatches++;
		end
		if (want.minute_pos !== got.minute_pos) begin
			$display("%0t ns: minute_byte_position expected %0d actual %0d",
				$time, want.minute_pos, got.minute_pos);
			mismatches++;
		end
		if (want.page_pos !== got.page_pos) begin
			$display("%0t ns: page_byte_position expected %0d actual %0d",
				$time, want.page_pos, got.page_pos);
			mismatches++;
		end
		if (want.full !== got.full) begin
			$display("%0t ns: store_full_event expected %0d actual %0d",
				$time, want.full, got.full);
			mismatches++;
		end
	endtask

	// called at a falling edge, returns at a falling edge after the sender's gap
	task automatic offer_sample(input logic [31:0] now, input logic typed,
			input minute_report_t want);
		minute_report_t predicted;
		int gap;
		sample_ch.valid <= 1'b1;
		sample_ch.now_ms <= now;
		do @(posedge clk); while (!sample_ch.ready);
		predicted = tally_time_sample(now);
		awaited_reports.push_back(typed ? want : predicted);
		samples_sent++;
		@(negedge clk);
		gap = draw_idle();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_for_results();
		sample_ch.valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_period(input logic [31:0] value);
		wait_for_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tick_period = value;
		periods_set++;
	endtask

	task automatic add_step(input step_kind_t kind, input logic [31:0] value,
			input logic typed, input minute_report_t want);
		table_row_t row;
		row.kind = kind;
		row.value = value;
		row.typed = typed;
		row.want = want;
		directed_steps.push_back(row);
	endtask

	// result side: random stall before each result
	initial begin : result_sink
		int stall;
		minute_report_t got;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = draw_idle();
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			got.counted = result_ch.minute_counted;
			got.total = result_ch.minute_total;
			got.minute_pos = result_ch.minute_byte_position;
			got.page_pos = result_ch.page_byte_position;
			got.full = result_ch.store_full_event;
			if (awaited_reports.size() == 0) begin
				$display("%0t ns: result with no request pending, total %0d",
					$time, got.total);
				mismatches++;
			end else begin
				compare_report(awaited_reports.pop_front(), got);
			end
		end
	end

	initial begin : stimulus
		logic [31:0] phase_periods [7];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.now_ms = '0;

		tick_period = fuc_pkg::PERIOD_RESET;
		last_tick = '0;
		minute_sum = '0;
		erase_level(LVL_MINUTE);
		erase_level(LVL_PAGE);

		// reset period, time wrap on the due sum, then both period extremes
		add_step(STEP_SAMPLE, 32'd0, 1'b1, minute_report_t'{1'b0, 32'd0, 7'd0, 7'd0, 1'b0});
		add_step(STEP_SAMPLE, 32'd59999, 1'b1, minute_report_t'{1'b0, 32'd0, 7'd0, 7'd0, 1'b0});
		add_step(STEP_SAMPLE, 32'd60000, 1'b1, minute_report_t'{1'b1, 32'd1, 7'd0, 7'd0, 1'b0});
		add_step(STEP_SAMPLE, 32'hFFFF_FFFF, 1'b1,
			minute_report_t'{1'b1, 32'd2, 7'd0, 7'd0, 1'b0});
		add_step(STEP_SAMPLE, 32'd0, 1'b1, minute_report_t'{1'b0, 32'd2, 7'd0, 7'd0, 1'b0});
		add_step(STEP_SAMPLE, 32'd59999, 1'b1, minute_report_t'{1'b1, 32'd3, 7'd0, 7'd0, 1'b0});
		add_step(STEP_PERIOD, 32'd1, 1'b0, '0);
		add_step(STEP_SAMPLE, 32'd59999, 1'b0, '0);
		// walk the first byte to zero and onto the next one
		for (int i = 0; i < 7; i++)
			add_step(STEP_SAMPLE, 32'd60000 + 32'(i), 1'b0, '0);
		add_step(STEP_PERIOD, 32'hFFFF_FFFF, 1'b0, '0);
		add_step(STEP_SAMPLE, 32'd60006, 1'b0, '0);
		add_step(STEP_SAMPLE, 32'd0, 1'b0, '0);
		add_step(STEP_SAMPLE, 32'hFFFF_FFFF, 1'b0, '0);
		add_step(STEP_PERIOD, 32'h8000_0000, 1'b0, '0);
		add_step(STEP_SAMPLE, 32'h7FFF_FFFF, 1'b0, '0);
		add_step(STEP_SAMPLE, 32'h8000_0000, 1'b0, '0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == STEP_PERIOD)
				write_period(directed_steps[i].value);
			else
				offer_sample(directed_steps[i].value, directed_steps[i].typed,
					directed_steps[i].want);
		end

		phase_periods[0] = 32'd1;
		phase_periods[1] = fuc_pkg::PERIOD_RESET;
		phase_periods[2] = 32'hFFFF_FFFF;
		phase_periods[3] = 32'($urandom_range(2, 100000));
		phase_periods[4] = 32'h8000_0000;
		phase_periods[5] = 32'($urandom_range(1, 32'hFFFF_FFFF));
		phase_periods[6] = 32'd1000;

		foreach (phase_periods[p]) begin
			write_period(phase_periods[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 39) == 0)
					steady_flow = !steady_flow;
				// sender holds off until the pipeline is empty
				if ($urandom_range(0, 199) == 0)
					wait_for_results();
				offer_sample(pick_now(), 1'b0, '0);
			end
		end

		wait_for_results();
		$display("covered %0d samples over %0d tick periods, idle 0..%0d on both sides",
			samples_sent, periods_set, MAX_IDLE);
		$display("%0d minutes counted, %0d minute-store rollovers, %0d full events",
			minutes_counted, minute_rollovers, full_events);
		if (mismatches == 0)
			$display("PASS flash_unary_minute_counter");
		else
			$display("FAIL flash_unary_minute_counter");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("FAIL flash_unary_minute_counter");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/fuc_pkg.sv
rtl/fuc_if.sv
rtl/fuc_datapath.sv
rtl/fuc_ctrl.sv
rtl/flash_unary_minute_counter.sv
tb/flash_unary_minute_counter_tb.sv
